>>> design/sbeo_pkg.sv
// shared types and codes for the slot buffer with drop-oldest replacement
package sbeo_pkg;

    localparam int SLOTS_DEF = 8;

    localparam logic [1:0] ST_PLACED    = 2'd0;
    localparam logic [1:0] ST_DISPLACED = 2'd1;
    localparam logic [1:0] ST_TAKEN     = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    localparam logic OP_PLACE = 1'b0;
    localparam logic OP_TAKE  = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [15:0] request_id;
        logic [31:0] creation_time;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] out_id;
        logic [31:0] out_time;
        logic        now_full;
        logic        now_empty;
    } out_item_t;

endpackage

>>> design/slot_buffer_evict_oldest.sv
// slot buffer with circular placement and take pointers and drop-oldest replacement
//
// An item is taken when start is high and busy is low; exactly one result follows,
// shown for one cycle with done high, and it cannot be held off. Occupancy flags
// live in flip-flops and are cleared by reset; request ids and timestamps live in a
// single-port-write memory with a registered read, so no clearing pass is needed. A
// take on an empty buffer is answered from the idle state without a scan; a place
// into a free slot scans from the placement pointer past occupied slots; a take
// scans from the take pointer past free slots and then reads the entry out; a place
// into a full buffer runs a sweep that reads every stamp through the memory port to
// find the oldest and overwrites it. busy is low again in the cycle done is high.
module slot_buffer_evict_oldest #(
    parameter int SLOTS = sbeo_pkg::SLOTS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  sbeo_pkg::in_item_t   item,
    output logic                 done,
    output sbeo_pkg::out_item_t  result
);

    localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int DATA_W = 48;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PSCAN,
        S_TSCAN,
        S_TOUT,
        S_MIN,
        S_MDONE
    } state_t;

    state_t                 state_reg, state_next;
    sbeo_pkg::in_item_t     item_reg, item_next;
    logic [ADDR_W-1:0]      scan_reg, scan_next;
    logic [ADDR_W-1:0]      place_ptr_reg, place_ptr_next;
    logic [ADDR_W-1:0]      take_ptr_reg, take_ptr_next;
    logic [SLOTS-1:0]       busy_reg, busy_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       idx_reg, idx_next;
    logic [ADDR_W-1:0]      best_reg, best_next;
    logic [15:0]            best_tag_reg, best_tag_next;
    logic [31:0]            best_stamp_reg, best_stamp_next;
    logic                   done_reg, done_next;
    sbeo_pkg::out_item_t    result_reg, result_next;

    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;
    logic [DATA_W-1:0]      mem_wdata;
    logic [ADDR_W-1:0]      mem_raddr;
    logic [DATA_W-1:0]      rd_data_reg;
    logic [DATA_W-1:0]      mem [SLOTS];

    logic [CNT_W-1:0]       idx_m1;
    logic [ADDR_W-1:0]      cand;
    logic                   full_now;

    function automatic logic [ADDR_W-1:0] next_slot(input logic [ADDR_W-1:0] p);
        logic [ADDR_W-1:0] r;
        if (p == ADDR_W'(SLOTS - 1)) begin
            r = '0;
        end
        else begin
            r = p + ADDR_W'(1);
        end
        return r;
    endfunction

    assign idx_m1   = idx_reg - CNT_W'(1);
    assign cand     = idx_m1[ADDR_W-1:0];
    assign full_now = (count_reg == CNT_W'(SLOTS));

    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        scan_next       = scan_reg;
        place_ptr_next  = place_ptr_reg;
        take_ptr_next   = take_ptr_reg;
        busy_next       = busy_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        best_next       = best_reg;
        best_tag_next   = best_tag_reg;
        best_stamp_next = best_stamp_reg;
        done_next       = 1'b0;
        result_next     = result_reg;
        mem_we          = 1'b0;
        mem_waddr       = scan_reg;
        mem_wdata       = {item_reg.request_id, item_reg.creation_time};
        mem_raddr       = scan_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    item_next = item;
                    if (item.operation == sbeo_pkg::OP_PLACE)
                    begin
                        if (full_now)
                        begin
                            idx_next   = '0;
                            state_next = S_MIN;
                        end
                        else
                        begin
                            scan_next  = place_ptr_reg;
                            state_next = S_PSCAN;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        done_next             = 1'b1;
                        result_next.status    = sbeo_pkg::ST_EMPTY;
                        result_next.out_id    = '0;
                        result_next.out_time  = '0;
                        result_next.now_full  = 1'b0;
                        result_next.now_empty = 1'b1;
                    end
                    else
                    begin
                        scan_next  = take_ptr_reg;
                        state_next = S_TSCAN;
                    end
                end
            end
            S_PSCAN:
            begin
                if (!busy_reg[scan_reg])
                begin
                    mem_we                = 1'b1;
                    busy_next[scan_reg]   = 1'b1;
                    place_ptr_next        = next_slot(scan_reg);
                    count_next            = count_reg + CNT_W'(1);
                    done_next             = 1'b1;
                    result_next.status    = sbeo_pkg::ST_PLACED;
                    result_next.out_id    = '0;
                    result_next.out_time  = '0;
                    result_next.now_full  = (count_reg == CNT_W'(SLOTS - 1));
                    result_next.now_empty = 1'b0;
                    state_next            = S_IDLE;
                end
                else
                begin
                    scan_next = next_slot(scan_reg);
                end
            end
            S_TSCAN:
            begin
                // the read issued here returns in the next cycle
                if (busy_reg[scan_reg])
                begin
                    busy_next[scan_reg] = 1'b0;
                    take_ptr_next       = next_slot(scan_reg);
                    count_next          = count_reg - CNT_W'(1);
                    state_next          = S_TOUT;
                end
                else
                begin
                    scan_next = next_slot(scan_reg);
                end
            end
            S_TOUT:
            begin
                done_next             = 1'b1;
                result_next.status    = sbeo_pkg::ST_TAKEN;
                result_next.out_id    = rd_data_reg[DATA_W-1:32];
                result_next.out_time  = rd_data_reg[31:0];
                result_next.now_full  = 1'b0;
                result_next.now_empty = (count_reg == '0);
                state_next            = S_IDLE;
            end
            S_MIN:
            begin
                // read slot idx while comparing the stamp of slot idx-1
                mem_raddr = idx_reg[ADDR_W-1:0];
                if (idx_reg != '0)
                begin
                    if ((idx_reg == CNT_W'(1)) || (rd_data_reg[31:0] < best_stamp_reg))
                    begin
                        best_next       = cand;
                        best_tag_next   = rd_data_reg[DATA_W-1:32];
                        best_stamp_next = rd_data_reg[31:0];
                    end
                end
                if (idx_reg == CNT_W'(SLOTS))
                begin
                    state_next = S_MDONE;
                end
                else
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            S_MDONE:
            begin
                mem_we                = 1'b1;
                mem_waddr             = best_reg;
                done_next             = 1'b1;
                result_next.status    = sbeo_pkg::ST_DISPLACED;
                result_next.out_id    = best_tag_reg;
                result_next.out_time  = best_stamp_reg;
                result_next.now_full  = 1'b1;
                result_next.now_empty = 1'b0;
                state_next            = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            place_ptr_reg  <= '0;
            take_ptr_reg   <= '0;
            busy_reg       <= '0;
            count_reg      <= '0;
            idx_reg        <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            place_ptr_reg  <= place_ptr_next;
            take_ptr_reg   <= take_ptr_next;
            busy_reg       <= busy_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        scan_reg       <= scan_next;
        best_reg       <= best_next;
        best_tag_reg   <= best_tag_next;
        best_stamp_reg <= best_stamp_next;
        result_reg     <= result_next;
    end

    // id and stamp store
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == CNT_W'($countones(busy_reg)))
        else $error("occupancy count out of step with slot flags");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("result shown while an item is still at work");

    a_displace_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (result_reg.status == sbeo_pkg::ST_DISPLACED)) |-> result_reg.now_full)
        else $error("displacing place without a full buffer");

    a_take_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (result_reg.status == sbeo_pkg::ST_TAKEN)) |-> !result_reg.now_full)
        else $error("buffer still full after a take");
`endif

endmodule

>>> dv/tb.sv
// self-checking testbench for the slot buffer with drop-oldest replacement
`timescale 1ns / 1ps

module tb;

    localparam int NSLOTS = sbeo_pkg::SLOTS_DEF;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    sbeo_pkg::in_item_t  item;
    logic                done;
    sbeo_pkg::out_item_t result;

    // predicted buffer contents and pointers
    logic              occupied [NSLOTS];
    logic [15:0]       held_id [NSLOTS];
    logic [31:0]       held_stamp [NSLOTS];
    int                place_at;
    int                take_at;

    sbeo_pkg::out_item_t outcome_q [$];
    sbeo_pkg::out_item_t want;
    int                  mismatches;
    int                  idle_pct;
    logic [31:0]         stamp_clock;

    slot_buffer_evict_oldest DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("[slot_buffer_evict_oldest] ERROR");
        $finish;
    end

    function automatic int count_occupied();
        int n;
        n = 0;
        for (int i = 0; i < NSLOTS; i++)
            if (occupied[i])
                n++;
        return n;
    endfunction

    // outcome of one item, updating the predicted buffer
    function automatic sbeo_pkg::out_item_t slot_outcome(sbeo_pkg::in_item_t it);
        sbeo_pkg::out_item_t r;
        int                  p;
        int                  oldest;
        r = '0;
        if (it.operation == sbeo_pkg::OP_PLACE)
        begin
            if (count_occupied() < NSLOTS)
            begin
                p = place_at;
                for (int k = 0; k < NSLOTS && occupied[p]; k++)
                    p = (p + 1) % NSLOTS;
                occupied[p]   = 1'b1;
                held_id[p]    = it.request_id;
                held_stamp[p] = it.creation_time;
                place_at      = (p + 1) % NSLOTS;
                r.status      = sbeo_pkg::ST_PLACED;
            end
            else
            begin
                // strictly smaller stamp needed, so the lowest index wins ties
                oldest = 0;
                for (int i = 1; i < NSLOTS; i++)
                    if (held_stamp[i] < held_stamp[oldest])
                        oldest = i;
                r.status           = sbeo_pkg::ST_DISPLACED;
                r.out_id           = held_id[oldest];
                r.out_time         = held_stamp[oldest];
                held_id[oldest]    = it.request_id;
                held_stamp[oldest] = it.creation_time;
            end
        end
        else if (count_occupied() == 0)
        begin
            r.status = sbeo_pkg::ST_EMPTY;
        end
        else
        begin
            p = take_at;
            for (int k = 0; k < NSLOTS && !occupied[p]; k++)
                p = (p + 1) % NSLOTS;
            r.status    = sbeo_pkg::ST_TAKEN;
            r.out_id    = held_id[p];
            r.out_time  = held_stamp[p];
            occupied[p] = 1'b0;
            take_at     = (p + 1) % NSLOTS;
        end
        r.now_full  = (count_occupied() == NSLOTS);
        r.now_empty = (count_occupied() == 0);
        return r;
    endfunction

    task automatic check_field(input string field, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (act_v !== exp_v)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, field, exp_v, act_v);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (outcome_q.size() == 0)
            begin
                $display("%0t: result with no item outstanding, actual %0h", $time, result);
                mismatches++;
            end
            else
            begin
                want = outcome_q.pop_front();
                check_field("status", 32'(want.status), 32'(result.status));
                check_field("out_id", 32'(want.out_id), 32'(result.out_id));
                check_field("out_time", want.out_time, result.out_time);
                check_field("now_full", 32'(want.now_full), 32'(result.now_full));
                check_field("now_empty", 32'(want.now_empty), 32'(result.now_empty));
            end
        end
    end

    // start is left high on return, unless a random idle gap drops it, so back-to-back items need no new start pulse
    task automatic send_item(input sbeo_pkg::in_item_t it);
        sbeo_pkg::out_item_t pred;
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pred = slot_outcome(it);
        outcome_q.insert(outcome_q.size(), pred);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
    endtask

    task automatic place(input logic [15:0] id, input logic [31:0] tm);
        send_item('{operation: sbeo_pkg::OP_PLACE, request_id: id, creation_time: tm});
    endtask

    task automatic take();
        send_item('{operation: sbeo_pkg::OP_TAKE, request_id: 16'($urandom),
                    creation_time: $urandom});
    endtask

    task automatic wait_all_back();
        start <= 1'b0;
        while (outcome_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_take_empty();
        take();
    endtask

    task automatic test_fill_extremes();
        place(16'h0000, 32'h0000_0010);
        place(16'hFFFF, 32'hFFFF_FFFF);
        place(16'h1234, 32'h0000_0000);
        place(16'hABCD, 32'h0000_0010);
        place(16'h5555, 32'h8000_0000);
        place(16'hAAAA, 32'h7FFF_FFFF);
        place(16'h0001, 32'h0000_0010);
        place(16'h8000, 32'h0000_0001);
    endtask

    task automatic test_displace_oldest();
        place(16'h7777, 32'hFFFF_FFFF);
        place(16'h3C3C, 32'h0000_0020);
        // three slots now tie on the smallest stamp
        place(16'hC3C3, 32'h0000_0030);
    endtask

    task automatic test_take_and_refill();
        repeat (3) take();
        place(16'h0F0F, 32'h0000_0002);
        place(16'hF0F0, 32'hFFFF_FFFE);
        repeat (8) take();
    endtask

    task automatic test_random(input int pct, input int items);
        int          take_pct;
        logic [15:0] id;
        logic [31:0] tm;
        idle_pct = pct;
        take_pct = 50;
        for (int n = 0; n < items; n++)
        begin
            // swing between filling and draining so full and empty both recur
            if (n % 16 == 0)
                case ($urandom_range(2))
                    0: take_pct = 20;
                    1: take_pct = 50;
                    default: take_pct = 80;
                endcase
            if ($urandom_range(99) < take_pct)
                take();
            else
            begin
                id = 16'($urandom);
                case ($urandom_range(3))
                    0: tm = $urandom_range(0, 7);
                    1: tm = $urandom;
                    2: tm = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
                    default:
                    begin
                        stamp_clock = stamp_clock + $urandom_range(0, 3);
                        tm = stamp_clock;
                    end
                endcase
                place(id, tm);
            end
        end
        wait_all_back();
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        item        = '0;
        mismatches  = 0;
        idle_pct    = 0;
        stamp_clock = 32'h0000_0100;
        place_at    = 0;
        take_at     = 0;
        for (int i = 0; i < NSLOTS; i++)
        begin
            occupied[i]   = 1'b0;
            held_id[i]    = '0;
            held_stamp[i] = '0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_take_empty();
        test_fill_extremes();
        test_displace_oldest();
        test_take_and_refill();
        wait_all_back();

        test_random(0, 260);
        test_random(74, 260);
        test_random(25, 260);
        test_random(0, 260);

        repeat (30) @(posedge clk);
        if (mismatches == 0)
            $display("[slot_buffer_evict_oldest] OK");
        else
            $display("[slot_buffer_evict_oldest] ERROR");
        $finish;
    end

endmodule
